// File: rtl/dmph_pkg.sv
package dmph_pkg;

	localparam int CHUNK_W = 32;
	localparam int BYTES_W = 2;
	localparam int LEN_W   = 32;
	localparam int BASE_W  = 30;
	localparam int ACC_W   = 30;
	localparam int HASH_W  = 62;
	localparam int IDX_W   = 1;

	// chunk size codes
	localparam logic [BYTES_W-1:0] BYTES_NONE = 2'd0;
	localparam logic [BYTES_W-1:0] BYTES_ONE  = 2'd1;
	localparam logic [BYTES_W-1:0] BYTES_TWO  = 2'd2;
	localparam logic [BYTES_W-1:0] BYTES_FOUR = 2'd3;

	// config register indexes
	localparam logic [IDX_W-1:0] REG_BASE_ONE = 1'b0;
	localparam logic [IDX_W-1:0] REG_BASE_TWO = 1'b1;

	localparam logic [BASE_W-1:0] BASE_ONE_RST = 30'd131;
	localparam logic [BASE_W-1:0] BASE_TWO_RST = 30'd137;

	localparam logic [ACC_W-1:0] MOD_ONE = 30'd1000000007;
	localparam logic [ACC_W-1:0] MOD_TWO = 30'd1000000009;

	// 3*p, added so that a negative chunk keeps the sum positive
	localparam logic [31:0] MOD3_ONE = 32'd3000000021;
	localparam logic [31:0] MOD3_TWO = 32'd3000000027;

	// Barrett factors floor(2^60 / p)
	localparam logic [63:0] MU_ONE_FULL = (64'd1 << 60) / 64'd1000000007;
	localparam logic [63:0] MU_TWO_FULL = (64'd1 << 60) / 64'd1000000009;
	localparam logic [30:0] MU_ONE = MU_ONE_FULL[30:0];
	localparam logic [30:0] MU_TWO = MU_TWO_FULL[30:0];

endpackage

// File: rtl/dmph_if.sv
interface dmph_msg_if;
	logic                             valid;
	logic                             ready;
	logic [dmph_pkg::CHUNK_W-1:0]     chunk;
	logic [dmph_pkg::BYTES_W-1:0]     chunk_bytes;
	logic                             first;
	logic                             last;
	logic [dmph_pkg::LEN_W-1:0]       total_len;

	modport source (output valid, chunk, chunk_bytes, first, last, total_len, input ready);
	modport sink   (input valid, chunk, chunk_bytes, first, last, total_len, output ready);
endinterface

interface dmph_hash_if;
	logic                          valid;
	logic                          ready;
	logic [dmph_pkg::HASH_W-1:0]   hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

// File: rtl/dual_modular_polynomial_hash.sv
// Two polynomial hashes, modulo 1000000007 and 1000000009, over a message sent
// as little-endian chunks (4-byte words, then an optional 2-byte and 1-byte
// tail). One word is taken at a time: msg.ready is high only while the block
// is idle. A single 32x32 multiplier with a registered product is shared by the
// multiply steps; a chunk update goes through base multiply, chunk add, Barrett
// estimate, quotient times modulus, subtract and compare-subtract until below
// the modulus. A first word costs two reductions of total_len, and a word with
// data one chunk update per modulus more; a word with neither returns to idle,
// or goes to emit if last. Results sit in an output register, so a new word is
// taken while the hash waits. Bases are written through cfg_we/cfg_idx/cfg_wdata;
// the user must do so only while idle, as the block does not enforce it.
module dual_modular_polynomial_hash (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dmph_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [dmph_pkg::BASE_W-1:0]  cfg_wdata,
	dmph_msg_if.sink                     msg,
	dmph_hash_if.source                  hash
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PROD = 3'd1;
	localparam logic [2:0] ST_XSUM = 3'd2;
	localparam logic [2:0] ST_QEST = 3'd3;
	localparam logic [2:0] ST_QP   = 3'd4;
	localparam logic [2:0] ST_SUB  = 3'd5;
	localparam logic [2:0] ST_CORR = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0]                       state_q;
	logic                             sel_q;
	logic                             absorb_q;
	logic [dmph_pkg::BASE_W-1:0]      base_one_q, base_two_q;
	logic [dmph_pkg::ACC_W-1:0]       acc_one_q, acc_two_q;
	logic                             out_valid_q;
	logic [dmph_pkg::HASH_W-1:0]      out_q;

	logic [dmph_pkg::CHUNK_W-1:0]     chunk_q;
	logic [dmph_pkg::BYTES_W-1:0]     bytes_q;
	logic                             last_q;
	logic [60:0]                      x_q;
	logic [63:0]                      prod_q;
	logic [33:0]                      r_q;

	logic [dmph_pkg::ACC_W-1:0]       mod_sel, acc_sel, base_sel;
	logic [30:0]                      mu_sel;
	logic [31:0]                      mod3_sel;
	logic [31:0]                      mul_a, mul_b;
	logic [63:0]                      mul_p;
	logic [31:0]                      val;
	logic [60:0]                      x_sum;
	logic                             r_ge;
	logic                             in_acc;
	logic                             out_free;

	assign msg.ready  = (state_q == ST_IDLE);
	assign in_acc     = msg.valid && msg.ready;
	assign hash.valid = out_valid_q;
	assign hash.hash_value = out_q;
	assign out_free   = !out_valid_q || hash.ready;

	always_comb begin
		if (sel_q) begin
			mod_sel  = dmph_pkg::MOD_TWO;
			mu_sel   = dmph_pkg::MU_TWO;
			mod3_sel = dmph_pkg::MOD3_TWO;
			acc_sel  = acc_two_q;
			base_sel = base_two_q;
		end else begin
			mod_sel  = dmph_pkg::MOD_ONE;
			mu_sel   = dmph_pkg::MU_ONE;
			mod3_sel = dmph_pkg::MOD3_ONE;
			acc_sel  = acc_one_q;
			base_sel = base_one_q;
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_PROD: begin
				mul_a = {2'b0, acc_sel};
				mul_b = {2'b0, base_sel};
			end
			ST_QEST: begin
				mul_a = x_q[60:29];
				mul_b = {1'b0, mu_sel};
			end
			default: begin
				mul_a = prod_q[62:31];
				mul_b = {2'b0, mod_sel};
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		unique case (bytes_q)
			dmph_pkg::BYTES_ONE: val = {{24{chunk_q[7]}}, chunk_q[7:0]};
			dmph_pkg::BYTES_TWO: val = {{16{chunk_q[15]}}, chunk_q[15:0]};
			default:             val = chunk_q;
		endcase
	end

	assign x_sum = {1'b0, prod_q[59:0]} + {{29{val[31]}}, val} + {29'b0, mod3_sel};
	assign r_ge  = r_q >= {4'b0, mod_sel};

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			chunk_q <= msg.chunk;
			bytes_q <= msg.chunk_bytes;
			last_q  <= msg.last;
			x_q     <= {29'b0, msg.total_len};
		end
		if (state_q == ST_PROD || state_q == ST_QEST || state_q == ST_QP) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_XSUM) begin
			x_q <= x_sum;
		end
		if (state_q == ST_SUB) begin
			r_q <= x_q[33:0] - prod_q[33:0];
		end else if (state_q == ST_CORR && r_ge) begin
			r_q <= r_q - {4'b0, mod_sel};
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q <= {acc_one_q, 2'b0, acc_two_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			absorb_q    <= 1'b0;
			base_one_q  <= dmph_pkg::BASE_ONE_RST;
			base_two_q  <= dmph_pkg::BASE_TWO_RST;
			acc_one_q   <= '0;
			acc_two_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					dmph_pkg::REG_BASE_ONE: base_one_q <= cfg_wdata;
					dmph_pkg::REG_BASE_TWO: base_two_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (hash.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sel_q <= 1'b0;
						if (msg.first) begin
							absorb_q <= 1'b0;
							state_q  <= ST_QEST;
						end else if (msg.chunk_bytes != dmph_pkg::BYTES_NONE) begin
							absorb_q <= 1'b1;
							state_q  <= ST_PROD;
						end else if (msg.last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_PROD: state_q <= ST_XSUM;
				ST_XSUM: state_q <= ST_QEST;
				ST_QEST: state_q <= ST_QP;
				ST_QP:   state_q <= ST_SUB;
				ST_SUB:  state_q <= ST_CORR;
				ST_CORR: begin
					if (!r_ge) begin
						if (!sel_q) begin
							acc_one_q <= r_q[dmph_pkg::ACC_W-1:0];
							sel_q     <= 1'b1;
							state_q   <= absorb_q ? ST_PROD : ST_QEST;
						end else begin
							acc_two_q <= r_q[dmph_pkg::ACC_W-1:0];
							sel_q     <= 1'b0;
							if (!absorb_q && bytes_q != dmph_pkg::BYTES_NONE) begin
								absorb_q <= 1'b1;
								state_q  <= ST_PROD;
							end else if (last_q) begin
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
